// ===== rtl/load_value_classification_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Load value classification table: assertion macros
// Concurrent assertion helpers. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef LOAD_VALUE_CLASSIFICATION_TABLE_TOP_DEFINES_SVH
`define LOAD_VALUE_CLASSIFICATION_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define LVCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define LVCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define LVCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LVCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lvct_pkg.sv =====
// ----------------------------------------------------------------------------
// Load value classification table: package
// Shared constants, field widths and codes.
// ----------------------------------------------------------------------------
package lvct_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int COUNTER_WIDTH_DEF = 5;

	// The entry index starts above the byte offset of a 4-byte instruction.
	localparam int ADDR_SHIFT = 2;
	localparam int ADDR_W     = 64;
	localparam int THRESH_W   = 5;
	localparam int CONF_W     = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [THRESH_W-1:0] THRESH_RESET     = 5'd30;
	localparam logic                CLEAR_MODE_RESET = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD  = 1'b0,
		CFG_CLEAR_MODE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_TRAIN  = 1'b1
	} cmd_t;

endpackage

// ===== rtl/lvct_if.sv =====
// ----------------------------------------------------------------------------
// Load value classification table: channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvct_req_if;
	logic                       valid;
	logic                       ready;
	lvct_pkg::cmd_t             command;
	logic [lvct_pkg::ADDR_W-1:0] load_address;
	logic                       was_correct;

	modport source (output valid, command, load_address, was_correct, input ready);
	modport sink   (input valid, command, load_address, was_correct, output ready);
endinterface

interface lvct_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        is_constant;
	logic [lvct_pkg::CONF_W-1:0] confidence;

	modport source (output valid, is_constant, confidence, input ready);
	modport sink   (input valid, is_constant, confidence, output ready);
endinterface

// ===== rtl/load_value_classification_table_top.sv =====
// ----------------------------------------------------------------------------
// Load value classification table: top level
// Saturating confidence counters indexed by load address, with lookup and
// training commands.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      payload
//  req      in         valid / ready  command, load_address, was_correct
//  rsp      out        valid / ready  is_constant, confidence
//  cfg      in         cfg_we         cfg_index, cfg_data
//
// One transaction per cycle unless rsp stalls or the clearing sweep runs; a
// result passes the registered memory read and then the result register.
// The counter read-modify-write is bypassed between back-to-back requests.
// After reset the memory is cleared one entry per cycle, every entry in turn,
// during which req.ready stays low.
// A stalled rsp holds one result; one more request waits in the read stage.
`include "load_value_classification_table_top_defines.svh"

module load_value_classification_table_top #(
	parameter int TABLE_ENTRIES = lvct_pkg::TABLE_ENTRIES_DEF,
	parameter int COUNTER_WIDTH = lvct_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lvct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lvct_pkg::CFG_DATA_W-1:0] cfg_data,
	lvct_req_if.sink                      req,
	lvct_rsp_if.source                    rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CMP_W = (COUNTER_WIDTH > lvct_pkg::THRESH_W) ?
		COUNTER_WIDTH : lvct_pkg::THRESH_W;
	localparam logic [COUNTER_WIDTH-1:0] CTR_MAX = {COUNTER_WIDTH{1'b1}};

	logic [lvct_pkg::THRESH_W-1:0] threshold_q;
	logic                          clear_mode_q;

	logic                     accept;
	logic                     s1_adv;
	logic                     busy;
	logic [IDX_W-1:0]         req_idx;
	logic [COUNTER_WIDTH-1:0] rd_data;

	logic                     s1_valid_q;
	lvct_pkg::cmd_t           cmd_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     correct_s1;
	logic                     fwd_s1;
	logic [COUNTER_WIDTH-1:0] fwd_data_s1;

	logic [COUNTER_WIDTH-1:0] ctr_old;
	logic [COUNTER_WIDTH-1:0] ctr_new;
	logic                     old_ge;
	logic                     new_ge;
	logic                     wr_en;

	logic                        out_valid_q;
	logic                        is_constant_q;
	logic [lvct_pkg::CONF_W-1:0] confidence_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= lvct_pkg::THRESH_RESET;
			clear_mode_q <= lvct_pkg::CLEAR_MODE_RESET;
		end else if (cfg_we) begin
			case (lvct_pkg::cfg_idx_t'(cfg_index))
				lvct_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data[lvct_pkg::THRESH_W-1:0];
				lvct_pkg::CFG_CLEAR_MODE: clear_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign req_idx = IDX_W'((req.load_address >> lvct_pkg::ADDR_SHIFT) &
		lvct_pkg::ADDR_W'(TABLE_ENTRIES - 1));

	assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !busy && (!s1_valid_q || s1_adv);
	assign accept    = req.valid && req.ready;

	lvct_table #(
		.ENTRIES (TABLE_ENTRIES),
		.CW      (COUNTER_WIDTH),
		.IDX_W   (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (req_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (ctr_new),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !s1_adv);
		end
	end

	// The memory is written at the same edge the next request reads it, so a
	// request to the same entry takes the freshly computed value instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= req.command;
			idx_s1      <= req_idx;
			correct_s1  <= req.was_correct;
			fwd_s1      <= s1_adv && (idx_s1 == req_idx);
			fwd_data_s1 <= ctr_new;
		end
	end

	assign ctr_old = fwd_s1 ? fwd_data_s1 : rd_data;
	assign old_ge  = CMP_W'(ctr_old) >= CMP_W'(threshold_q);

	always_comb begin
		ctr_new = ctr_old;
		if (cmd_s1 == lvct_pkg::CMD_TRAIN) begin
			if (correct_s1) begin
				if (ctr_old != CTR_MAX) begin
					ctr_new = ctr_old + 1'b1;
				end
			end else if (clear_mode_q) begin
				if (old_ge) begin
					ctr_new = '0;
				end
			end else if (ctr_old != '0) begin
				ctr_new = ctr_old - 1'b1;
			end
		end
	end

	assign new_ge = CMP_W'(ctr_new) >= CMP_W'(threshold_q);
	assign wr_en  = s1_adv && (cmd_s1 == lvct_pkg::CMD_TRAIN);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= s1_adv || (out_valid_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			is_constant_q <= new_ge;
			confidence_q  <= lvct_pkg::CONF_W'(ctr_new);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.is_constant = is_constant_q;
	assign rsp.confidence  = confidence_q;

	`LVCT_ASSERT_IMPLY(a_no_work_while_clearing, clk, arst_n, busy, !s1_valid_q && !accept)
	`LVCT_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, s1_valid_q)
	`LVCT_ASSERT_NEXT(a_adv_fills_rsp, clk, arst_n, s1_adv, rsp.valid)
	`LVCT_ASSERT_IMPLY(a_train_inc, clk, arst_n,
		s1_adv && (cmd_s1 == lvct_pkg::CMD_TRAIN) && correct_s1 && (ctr_old != CTR_MAX),
		ctr_new == ctr_old + 1'b1)

endmodule

// ===== rtl/lvct_table.sv =====
// ----------------------------------------------------------------------------
// Load value classification table: counter memory
// Single-port-write, registered-read counter storage with a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
module lvct_table #(
	parameter int ENTRIES = lvct_pkg::TABLE_ENTRIES_DEF,
	parameter int CW      = lvct_pkg::COUNTER_WIDTH_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [CW-1:0]    rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [CW-1:0]    wr_data,
	output logic             busy
);

	logic [CW-1:0]    mem [ENTRIES];
	logic [CW-1:0]    rd_data_q;
	logic             clr_active_q;
	logic [IDX_W-1:0] clr_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_ptr_q    <= '0;
		end else if (clr_active_q) begin
			clr_ptr_q <= clr_ptr_q + 1'b1;
			if (clr_ptr_q == IDX_W'(ENTRIES - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_ptr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_active_q;

endmodule

// ===== sim/load_value_classification_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load value classification table: testbench
// Drives lookup and training transactions through the request channel and
// checks every response against a scoreboard that mirrors the counter table.
// A short table of hand-picked requests runs first. Random phases follow,
// one per threshold and mode setting, with idle cycles on both channels and
// long response stalls that back the block up.
// ----------------------------------------------------------------------------
module load_value_classification_table_top_tb;

	localparam int CLK_PERIOD    = 10;
	localparam int TABLE_ENTRIES = lvct_pkg::TABLE_ENTRIES_DEF;
	localparam int COUNTER_WIDTH = lvct_pkg::COUNTER_WIDTH_DEF;
	localparam int ADDR_W        = lvct_pkg::ADDR_W;
	localparam int ADDR_SHIFT    = lvct_pkg::ADDR_SHIFT;
	localparam int CONF_W        = lvct_pkg::CONF_W;
	localparam int THRESH_W      = lvct_pkg::THRESH_W;
	localparam int CFG_DATA_W    = lvct_pkg::CFG_DATA_W;
	localparam int CTR_MAX       = (1 << COUNTER_WIDTH) - 1;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 240;
	localparam int HOLD_CYCLES   = 200;
	localparam int HOT_SLOTS     = 4;

	typedef struct packed {
		logic              is_constant;
		logic [CONF_W-1:0] confidence;
	} verdict_t;

	typedef struct packed {
		lvct_pkg::cmd_t    command;
		logic [ADDR_W-1:0] load_address;
		logic              was_correct;
		logic              typed;
		verdict_t          want;
	} probe_row_t;

	bit                      clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	lvct_pkg::cfg_idx_t      cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	lvct_req_if req_ch();
	lvct_rsp_if rsp_ch();

	load_value_classification_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Scoreboard copy of the table and its settings.
	logic [COUNTER_WIDTH-1:0] confidence_mirror [TABLE_ENTRIES];
	logic [THRESH_W-1:0]      threshold_now = lvct_pkg::THRESH_RESET;
	logic                     clear_mode_now = lvct_pkg::CLEAR_MODE_RESET;

	verdict_t pending_verdicts [$];
	verdict_t head_verdict;

	int  fail_count     = 0;
	int  cycle_count    = 0;
	int  items_accepted = 0;
	int  results_seen   = 0;
	int  lookups        = 0;
	int  trainings      = 0;
	int  saturated_hits = 0;
	int  clears         = 0;
	int  floor_holds    = 0;
	int  constant_seen  = 0;
	bit  steady_run     = 1'b0;
	bit  hold_off       = 1'b0;

	logic [9:0] hot_slot [HOT_SLOTS];

	probe_row_t probe_rows [15] = '{
		'{lvct_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 1'b0, 1'b1, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_TRAIN,  64'h0000_0000_0000_0000, 1'b1, 1'b1, '{1'b0, 5'd1}},
		'{lvct_pkg::CMD_TRAIN,  64'h0000_0000_0000_0000, 1'b0, 1'b1, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_TRAIN,  64'h0000_0000_0000_0000, 1'b0, 1'b1, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0003, 1'b1, 1'b1, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_TRAIN,  64'h0000_0000_0000_0004, 1'b1, 1'b1, '{1'b0, 5'd1}},
		'{lvct_pkg::CMD_TRAIN,  64'h0000_0000_0000_1004, 1'b1, 1'b1, '{1'b0, 5'd2}},
		'{lvct_pkg::CMD_TRAIN,  64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 1'b1, '{1'b0, 5'd1}},
		'{lvct_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0FFC, 1'b0, 1'b1, '{1'b0, 5'd1}},
		'{lvct_pkg::CMD_TRAIN,  64'h8000_0000_0000_0004, 1'b0, 1'b1, '{1'b0, 5'd1}},
		'{lvct_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_TRAIN,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAB, 1'b1, 1'b0, '{1'b0, 5'd0}},
		'{lvct_pkg::CMD_TRAIN,  64'h0000_0000_0000_0FFF, 1'b1, 1'b1, '{1'b0, 5'd2}}
	};

	// Threshold and mode per random phase; a negative entry means pick at random.
	int phase_threshold [PHASES] = '{30, 0, 31, 31, -1, 1};
	int phase_mode      [PHASES] = '{0, 1, 0, 1, -1, 1};
	int phase_pct_right [PHASES] = '{85, 70, 90, 80, 75, 60};

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic verdict_t classify_and_train(lvct_pkg::cmd_t command,
			logic [ADDR_W-1:0] addr, logic was_correct);
		int unsigned              slot;
		logic [COUNTER_WIDTH-1:0] ctr;
		verdict_t                 v;
		slot = int'((addr >> ADDR_SHIFT) & ADDR_W'(TABLE_ENTRIES - 1));
		ctr  = confidence_mirror[slot];
		if (command == lvct_pkg::CMD_TRAIN) begin
			trainings++;
			if (was_correct) begin
				if (ctr != COUNTER_WIDTH'(CTR_MAX))
					ctr++;
				else
					saturated_hits++;
			end else if (clear_mode_now) begin
				if (ctr >= threshold_now) begin
					ctr = '0;
					clears++;
				end
			end else begin
				if (ctr != '0)
					ctr--;
				else
					floor_holds++;
			end
			confidence_mirror[slot] = ctr;
		end else begin
			lookups++;
		end
		v.is_constant = (ctr >= threshold_now);
		v.confidence  = CONF_W'(ctr);
		return v;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR at %0t: %s", $realtime, what);
	endtask

	// Offers one request, waits for the handshake, then records what should come back.
	task automatic send_request(input lvct_pkg::cmd_t command,
			input logic [ADDR_W-1:0] addr, input logic was_correct, input logic typed,
			input verdict_t typed_want);
		verdict_t predicted;
		if (!steady_run && $urandom_range(0, 99) < 25) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= command;
		req_ch.load_address <= addr;
		req_ch.was_correct  <= was_correct;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_accepted++;
		predicted = classify_and_train(command, addr, was_correct);
		pending_verdicts.push_back(typed ? typed_want : predicted);
	endtask

	// Drains the pipeline, then programs both registers while the block is idle.
	task automatic settle_and_configure(input logic [THRESH_W-1:0] thr, input logic mode);
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= lvct_pkg::CFG_THRESHOLD;
		cfg_data  <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_index <= lvct_pkg::CFG_CLEAR_MODE;
		cfg_data  <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_we         <= 1'b0;
		threshold_now  = thr;
		clear_mode_now = mode;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				pending_verdicts.size());
			$display("load_value_classification_table_top_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_ch.ready <= arst_n && !hold_off && (steady_run || $urandom_range(0, 99) >= 25);

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (rsp_ch.is_constant === 1'b1)
				constant_seen++;
			if (pending_verdicts.size() == 0) begin
				note_failure($sformatf("unexpected result is_constant=%0b confidence=%0d",
					rsp_ch.is_constant, rsp_ch.confidence));
			end else begin
				head_verdict = pending_verdicts.pop_front();
				if (rsp_ch.is_constant !== head_verdict.is_constant ||
						rsp_ch.confidence !== head_verdict.confidence)
					note_failure($sformatf(
						"result %0d: expected is_constant=%0b confidence=%0d, got %0b/%0d",
						results_seen, head_verdict.is_constant, head_verdict.confidence,
						rsp_ch.is_constant, rsp_ch.confidence));
			end
		end
	end

	// The receiver stalls twice for a long stretch while requests keep coming.
	initial begin
		wait (arst_n === 1'b1);
		wait (items_accepted >= 320);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
		wait (items_accepted >= 1100);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		logic [ADDR_W-1:0] addr;
		lvct_pkg::cmd_t    command;
		logic              right;
		int                thr_pick;
		int                mode_pick;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= lvct_pkg::CFG_THRESHOLD;
		cfg_data            <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.command      <= lvct_pkg::CMD_LOOKUP;
		req_ch.load_address <= '0;
		req_ch.was_correct  <= 1'b0;
		foreach (confidence_mirror[i])
			confidence_mirror[i] = '0;
		hot_slot[0] = 10'h000;
		hot_slot[1] = 10'h3FF;
		for (int i = 2; i < HOT_SLOTS; i++)
			hot_slot[i] = 10'($urandom());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked requests at the reset settings.
		for (int i = 0; i < $size(probe_rows); i++)
			send_request(probe_rows[i].command, probe_rows[i].load_address,
				probe_rows[i].was_correct, probe_rows[i].typed, probe_rows[i].want);

		// Most requests hit a few hot entries so that counters climb to saturation.
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				thr_pick  = (phase_threshold[p] < 0) ? $urandom_range(0, 31) :
					phase_threshold[p];
				mode_pick = (phase_mode[p] < 0) ? $urandom_range(0, 1) : phase_mode[p];
				settle_and_configure(THRESH_W'(thr_pick), mode_pick[0]);
			end
			steady_run <= (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				addr = {$urandom(), $urandom()};
				if ($urandom_range(0, 99) < 75) begin
					addr[11:2] = hot_slot[$urandom_range(0, HOT_SLOTS - 1)];
					command    = ($urandom_range(0, 99) < 80) ? lvct_pkg::CMD_TRAIN :
						lvct_pkg::CMD_LOOKUP;
				end else begin
					command    = ($urandom_range(0, 1) == 1) ? lvct_pkg::CMD_TRAIN :
						lvct_pkg::CMD_LOOKUP;
				end
				right = ($urandom_range(0, 99) < phase_pct_right[p]);
				send_request(command, addr, right, 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		steady_run   <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d lookups and %0d training steps over %0d register settings",
			lookups, trainings, PHASES);
		$display("saturated %0d, cleared %0d, held at zero %0d, %0d constant of %0d results",
			saturated_hits, clears, floor_holds, constant_seen, results_seen);
		if (fail_count == 0) begin
			$display("load_value_classification_table_top_tb: PASS");
		end else begin
			$display("%0d failures", fail_count);
			$display("load_value_classification_table_top_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== load_value_classification_table_top.f =====
+incdir+rtl
rtl/lvct_pkg.sv
rtl/lvct_if.sv
rtl/lvct_table.sv
rtl/load_value_classification_table_top.sv
sim/load_value_classification_table_top_tb.sv
